// File: rtl/afst_pkg.sv
// shared types, constants and register indexes of the slip traction block
package afst_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int CFG_WIDTH   = 16;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    // input reg, squares, sum, root, divide, 8 arithmetic stages, root, product, output
    localparam int LATENCY     = 3 + SQRT_STAGES + DIV_STAGES + 8 + SQRT_STAGES + 2;

    localparam logic [63:0] MAG_MAX =
        64'((65'd1 << (DATA_WIDTH - 1)) - 65'd1);
    localparam logic [63:0] MAG_MIN = MAG_MAX + 64'd1;
    localparam logic signed [DATA_WIDTH-1:0] TRACTION_MAX = MAG_MAX[DATA_WIDTH-1:0];
    localparam logic signed [DATA_WIDTH-1:0] TRACTION_MIN = MAG_MIN[DATA_WIDTH-1:0];

    typedef enum logic [2:0] {
        CFG_PRIMARY_COEFF   = 3'd0,
        CFG_SECONDARY_COEFF = 3'd1,
        CFG_DIR_X           = 3'd2,
        CFG_DIR_Y           = 3'd3,
        CFG_DIR_Z           = 3'd4,
        CFG_MIN_SLIP_LENGTH = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] pressure;
        logic signed [31:0] slip_x;
        logic signed [31:0] slip_y;
        logic signed [31:0] slip_z;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] traction;
        logic                         degenerate;
        logic                         saturated;
    } t_out;

endpackage

// File: rtl/anisotropic_friction_slip_traction.sv
// Slip traction for anisotropic Coulomb friction, one contact point per transaction.
// The block is a pipeline that accepts one transaction every cycle while the output is not
// stalled and presents results in order. The depth is set by the two bit-per-stage square
// roots (32 stages each) and the bit-per-stage slip normalising divider (31 stages). The
// whole pipeline holds when the output register is full and not taken, so o_in_ready
// follows i_out_ready in that case. Configuration registers must be written through the
// plain write port only while the pipeline is empty; the block itself does not enforce
// this.
module anisotropic_friction_slip_traction (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_idx,
    input  logic [afst_pkg::CFG_WIDTH-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  afst_pkg::t_in                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output afst_pkg::t_out                  o_out
);
    localparam int SQ  = afst_pkg::SQRT_STAGES;
    localparam int DV  = afst_pkg::DIV_STAGES;
    localparam int LAT = afst_pkg::LATENCY;

    typedef struct packed {
        logic [2:0][31:0]   mag;
        logic [2:0]         sgn;
        logic signed [31:0] pres;
    } t_side_len;

    typedef struct packed {
        logic [2:0]         sgn;
        logic signed [31:0] pres;
        logic               degen;
    } t_side_div;

    typedef struct packed {
        logic signed [31:0] pres;
        logic               degen;
    } t_side_mag;

    // configuration
    logic [15:0]        r_primary_coeff;
    logic [15:0]        r_secondary_coeff;
    logic signed [15:0] r_dir [3];
    logic [15:0]        r_min_slip_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primary_coeff   <= '0;
            r_secondary_coeff <= '0;
            r_dir[0]          <= 16'sd32767;
            r_dir[1]          <= '0;
            r_dir[2]          <= '0;
            r_min_slip_length <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                afst_pkg::CFG_PRIMARY_COEFF:   r_primary_coeff   <= i_cfg_data;
                afst_pkg::CFG_SECONDARY_COEFF: r_secondary_coeff <= i_cfg_data;
                afst_pkg::CFG_DIR_X:           r_dir[0]          <= i_cfg_data;
                afst_pkg::CFG_DIR_Y:           r_dir[1]          <= i_cfg_data;
                afst_pkg::CFG_DIR_Z:           r_dir[2]          <= i_cfg_data;
                afst_pkg::CFG_MIN_SLIP_LENGTH: r_min_slip_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: everything moves together
    logic r_vld [LAT];
    logic en;

    assign en          = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // input register
    afst_pkg::t_in r0_in;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_in <= i_in;
        end
    end

    // slip magnitudes and squares
    logic signed [31:0] slip0 [3];
    logic [31:0]        n1_mag [3];
    logic [31:0]        r1_mag [3];
    logic [2:0]         r1_sgn;
    logic [63:0]        r1_sq  [3];
    logic signed [31:0] r1_pres;

    assign slip0[0] = r0_in.slip_x;
    assign slip0[1] = r0_in.slip_y;
    assign slip0[2] = r0_in.slip_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = slip0[i][31] ? 32'(-slip0[i]) : 32'(slip0[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_mag[i] <= n1_mag[i];
                r1_sgn[i] <= slip0[i][31];
                r1_sq[i]  <= 64'(n1_mag[i]) * 64'(n1_mag[i]);
            end
            r1_pres <= r0_in.pressure;
        end
    end

    logic [63:0] r2_sumsq;
    t_side_len   r2_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_sumsq     <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            for (int i = 0; i < 3; i++) begin
                r2_side.mag[i] <= r1_mag[i];
            end
            r2_side.sgn  <= r1_sgn;
            r2_side.pres <= r1_pres;
        end
    end

    // slip length
    logic [31:0] len;
    t_side_len   r_dly_len [SQ];

    afst_sqrt u_sqrt_len (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r2_sumsq),
        .o_root  (len)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_len[0] <= r2_side;
            for (int k = 1; k < SQ; k++) begin
                r_dly_len[k] <= r_dly_len[k-1];
            end
        end
    end

    // normalise slip
    t_side_len   len_side;
    t_side_div   div_side_in;
    logic [DV-1:0] quo [3];
    t_side_div   r_dly_div [DV];

    assign len_side          = r_dly_len[SQ-1];
    assign div_side_in.sgn   = len_side.sgn;
    assign div_side_in.pres  = len_side.pres;
    assign div_side_in.degen = len <= {16'd0, r_min_slip_length};

    for (genvar i = 0; i < 3; i++) begin : g_div
        afst_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mag (len_side.mag[i]),
            .i_len (len),
            .o_quo (quo[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_div[0] <= div_side_in;
            for (int k = 1; k < DV; k++) begin
                r_dly_div[k] <= r_dly_div[k-1];
            end
        end
    end

    // projection onto the primary direction
    t_side_div          div_side;
    logic signed [31:0] n66_s [3];
    logic signed [31:0] r66_s [3];
    logic signed [47:0] r66_ds [3];
    t_side_mag          r66_side;

    assign div_side = r_dly_div[DV-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n66_s[i] = div_side.sgn[i] ? -$signed(32'(quo[i])) : $signed(32'(quo[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r66_s[i]  <= n66_s[i];
                r66_ds[i] <= r_dir[i] * n66_s[i];
            end
            r66_side.pres  <= div_side.pres;
            r66_side.degen <= div_side.degen;
        end
    end

    logic signed [49:0] acc;
    logic [49:0]        acc_mag;
    logic [34:0]        a_abs;
    logic signed [34:0] r67_a;
    logic signed [31:0] r67_s [3];
    t_side_mag          r67_side;

    assign acc     = 50'(r66_ds[0]) + 50'(r66_ds[1]) + 50'(r66_ds[2]);
    assign acc_mag = acc[49] ? 50'(-acc) : 50'(acc);
    assign a_abs   = 35'(acc_mag >> 15);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r67_a    <= acc[49] ? -$signed(a_abs) : $signed(a_abs);
            r67_s    <= r66_s;
            r67_side <= r66_side;
        end
    end

    logic signed [50:0] r68_ad [3];
    logic signed [31:0] r68_s  [3];
    t_side_mag          r68_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r68_ad[i] <= r67_a * r_dir[i];
            end
            r68_s    <= r67_s;
            r68_side <= r67_side;
        end
    end

    // split into parts along and across the direction
    logic [50:0]        ad_mag [3];
    logic [35:0]        p_abs  [3];
    logic signed [35:0] n69_p  [3];
    logic signed [35:0] r69_p  [3];
    logic signed [36:0] r69_q  [3];
    t_side_mag          r69_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ad_mag[i] = r68_ad[i][50] ? 51'(-r68_ad[i]) : 51'(r68_ad[i]);
            p_abs[i]  = 36'(ad_mag[i] >> 15);
            n69_p[i]  = r68_ad[i][50] ? -$signed(p_abs[i]) : $signed(p_abs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r69_p[i] <= n69_p[i];
                r69_q[i] <= 37'(r68_s[i]) - 37'(n69_p[i]);
            end
            r69_side <= r68_side;
        end
    end

    logic signed [52:0] r70_pp [3];
    logic signed [53:0] r70_qq [3];
    t_side_mag          r70_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r70_pp[i] <= $signed({1'b0, r_primary_coeff}) * r69_p[i];
                r70_qq[i] <= $signed({1'b0, r_secondary_coeff}) * r69_q[i];
            end
            r70_side <= r69_side;
        end
    end

    // weighted vector, only its magnitude is needed from here on
    logic signed [54:0] wsum  [3];
    logic [54:0]        w_mag [3];
    logic [31:0]        r71_w [3];
    t_side_mag          r71_side;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wsum[i]  = 55'(r70_pp[i]) + 55'(r70_qq[i]);
            w_mag[i] = wsum[i][54] ? 55'(-wsum[i]) : 55'(wsum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r71_w[i] <= 32'(w_mag[i] >> 18);
            end
            r71_side <= r70_side;
        end
    end

    logic [63:0] r72_sq [3];
    t_side_mag   r72_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r72_sq[i] <= 64'(r71_w[i]) * 64'(r71_w[i]);
            end
            r72_side <= r71_side;
        end
    end

    logic [63:0] r73_sumsq;
    t_side_mag   r73_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r73_sumsq <= r72_sq[0] + r72_sq[1] + r72_sq[2];
            r73_side  <= r72_side;
        end
    end

    // effective coefficient
    logic [31:0] coeff;
    t_side_mag   r_dly_mag [SQ];

    afst_sqrt u_sqrt_coeff (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_value (r73_sumsq),
        .o_root  (coeff)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_mag[0] <= r73_side;
            for (int k = 1; k < SQ; k++) begin
                r_dly_mag[k] <= r_dly_mag[k-1];
            end
        end
    end

    t_side_mag   mag_side;
    logic [31:0] pres_abs;
    logic [63:0] r106_prod;
    logic        r106_neg;
    logic        r106_degen;

    assign mag_side = r_dly_mag[SQ-1];
    assign pres_abs = mag_side.pres[31] ? 32'(-mag_side.pres) : 32'(mag_side.pres);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r106_prod  <= 64'(coeff) * 64'(pres_abs);
            r106_neg   <= mag_side.pres[31];
            r106_degen <= mag_side.degen;
        end
    end

    // scale back and saturate
    logic [63:0]    t_mag;
    afst_pkg::t_out n_out;
    afst_pkg::t_out r_out;

    always_comb begin
        t_mag            = r106_prod >> 24;
        n_out.degenerate = 1'b0;
        n_out.saturated  = 1'b0;
        if (r106_degen) begin
            n_out.traction   = afst_pkg::TRACTION_MAX;
            n_out.degenerate = 1'b1;
        end else if (r106_neg) begin
            if (t_mag > afst_pkg::MAG_MIN) begin
                t_mag           = afst_pkg::MAG_MIN;
                n_out.saturated = 1'b1;
            end
            n_out.traction = afst_pkg::DATA_WIDTH'(64'd0 - t_mag);
        end else begin
            if (t_mag > afst_pkg::MAG_MAX) begin
                t_mag           = afst_pkg::MAG_MAX;
                n_out.saturated = 1'b1;
            end
            n_out.traction = afst_pkg::DATA_WIDTH'(t_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// File: rtl/afst_sqrt.sv
// pipelined integer square root, one root bit per stage
module afst_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_value,
    output logic [31:0] o_root
);
    localparam int N = afst_pkg::SQRT_STAGES;

    logic [63:0] r_rem  [N-1];
    logic [63:0] r_root [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [63:0] rem_c;
        logic [63:0] root_c;
        logic [63:0] trial;

        if (k == 0) begin : g_first
            assign rem_c  = i_value;
            assign root_c = '0;
        end else begin : g_next
            assign rem_c  = r_rem[k-1];
            assign root_c = r_root[k-1];
        end

        assign trial = root_c + BITV;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_c >= trial) begin
                    r_root[k] <= (root_c >> 1) + BITV;
                end else begin
                    r_root[k] <= root_c >> 1;
                end
            end
        end

        if (k < N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= (rem_c >= trial) ? rem_c - trial : rem_c;
                end
            end
        end
    end

    assign o_root = r_root[N-1][31:0];

endmodule

// File: rtl/afst_div.sv
// pipelined restoring divider: (mag << 30) / len, one quotient bit per stage
module afst_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [31:0]                       i_mag,
    input  logic [31:0]                       i_len,
    output logic [afst_pkg::DIV_STAGES-1:0]   o_quo
);
    localparam int N = afst_pkg::DIV_STAGES;

    logic [31:0]  r_rem [N-1];
    logic [31:0]  r_len [N-1];
    logic [N-1:0] r_quo [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [31:0]  rem_c;
        logic [31:0]  len_c;
        logic [N-1:0] quo_c;
        logic         nb;
        logic [32:0]  shifted;
        logic         ge;

        // mag >> 1 is below len whenever the slip is not degenerate
        if (k == 0) begin : g_first
            assign rem_c = {1'b0, i_mag[31:1]};
            assign len_c = i_len;
            assign quo_c = '0;
            assign nb    = i_mag[0];
        end else begin : g_next
            assign rem_c = r_rem[k-1];
            assign len_c = r_len[k-1];
            assign quo_c = r_quo[k-1];
            assign nb    = 1'b0;
        end

        assign shifted = {rem_c, nb};
        assign ge      = shifted >= {1'b0, len_c};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k] <= {quo_c[N-2:0], ge};
            end
        end

        if (k < N - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? 32'(shifted - {1'b0, len_c}) : shifted[31:0];
                    r_len[k] <= len_c;
                end
            end
        end
    end

    assign o_quo = r_quo[N-1];

endmodule

// File: rtl/afst_checker.sv
// port-level checks of the slip traction block, bound to the top level
module afst_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input afst_pkg::t_out  o_out
);

    // a result waiting for the sink stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    // degenerate slip gives the largest positive traction, not saturated
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.degenerate |->
            !o_out.saturated && o_out.traction == afst_pkg::TRACTION_MAX)
        else $error("bad degenerate result");

    // a clipped traction sits at one end of the range
    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.saturated |->
            o_out.traction == afst_pkg::TRACTION_MAX ||
            o_out.traction == afst_pkg::TRACTION_MIN)
        else $error("saturated traction not at range limit");

endmodule

bind anisotropic_friction_slip_traction afst_checker u_afst_checker (.*);
